[sv/jets_pkg.sv]
// Shared types, constants and helpers for the Julia escape-time pixel unit.
// No dependencies; every other file of the block imports this package.
package jets_pkg;

	// Default parameter values
	localparam int FRAC_BITS_DEF  = 28;
	localparam int COORD_BITS_DEF = 12;

	// Fixed field widths
	localparam int DIM_BITS  = 13;
	localparam int HALF_BITS = DIM_BITS - 1;
	localparam int ZOOM_BITS = 31;
	localparam int ITER_BITS = 16;
	localparam int DEN_BITS  = ZOOM_BITS + DIM_BITS;

	// Quotient magnitude cap of the coordinate mapping
	localparam int                QW   = 41;
	localparam logic [QW-1:0]     QCAP = QW'(1) << (QW - 1);

	// Width used for saturating sums
	localparam int SAT_W = 66;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_WIDTH    = 3'd0,
		CFG_HEIGHT   = 3'd1,
		CFG_ZOOM     = 3'd2,
		CFG_OFF_RE   = 3'd3,
		CFG_OFF_IM   = 3'd4,
		CFG_C_RE     = 3'd5,
		CFG_C_IM     = 3'd6,
		CFG_MAX_ITER = 3'd7
	} jets_cfg_idx_t;

	typedef struct packed {
		logic [DIM_BITS-1:0]  width;
		logic [DIM_BITS-1:0]  height;
		logic [ZOOM_BITS-1:0] zoom;
		logic signed [31:0]   off_re;
		logic signed [31:0]   off_im;
		logic signed [31:0]   c_re;
		logic signed [31:0]   c_im;
		logic [ITER_BITS-1:0] max_iter;
	} jets_cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_MAP,
		ST_MULT,
		ST_STEP,
		ST_FINISH
	} jets_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic setup;
		logic div_step;
		logic map;
		logic mult;
		logic step;
		logic out_load;
	} jets_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic esc;
		logic at_limit;
		logic out_busy;
	} jets_sts_t;

	// Clamp a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic fits;
		fits = (v[SAT_W-1:31] == '0) || (v[SAT_W-1:31] == '1);
		if (fits)
			return v[31:0];
		else if (v[SAT_W-1])
			return 32'sh8000_0000;
		else
			return 32'sh7fff_ffff;
	endfunction

endpackage

[sv/julia_escape_time_pixel.sv]
// Top level of the Julia escape-time pixel unit: configuration registers,
// controller and datapath. Depends on jets_pkg, jets_ctrl, jets_datapath.
//
//  channel | signals                               | handshake
//  --------+---------------------------------------+----------------------------
//  in      | pixel_x, pixel_y                      | in_valid / in_ready
//  out     | iteration_count, inside_set, final_*  | out_valid / out_ready
//  cfg     | cfg_index, cfg_data                   | cfg_we, write only
//
// One pixel at a time, in order: accept, setup, one division step per dividend
// bit, map, the iterations until escape or max_iterations, then the result
// load. The two start-point dividers run one quotient bit a cycle; each
// iteration takes a multiply state and an update/test state on the shared unit.
// Reset returns the controller to idle, empties the result register and loads
// the register defaults. A stalled result beat holds its register while the
// next pixel is accepted and computed; the unit waits only to hand it over.
module julia_escape_time_pixel import jets_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [ITER_BITS-1:0]  iteration_count,
	output logic                  inside_set,
	output logic signed [31:0]    final_real,
	output logic signed [31:0]    final_imag,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data
);

	jets_cfg_t cfg_q;
	jets_cmd_t cmd;
	jets_sts_t sts;

	// Configuration register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width    <= DIM_BITS'(800);
			cfg_q.height   <= DIM_BITS'(800);
			cfg_q.zoom     <= ZOOM_BITS'(268435456);
			cfg_q.off_re   <= '0;
			cfg_q.off_im   <= '0;
			cfg_q.c_re     <= -32'sd187904819;
			cfg_q.c_im     <= 32'sd72517838;
			cfg_q.max_iter <= ITER_BITS'(100);
		end else if (cfg_we) begin
			unique case (jets_cfg_idx_t'(cfg_index))
				CFG_WIDTH:    cfg_q.width    <= cfg_data[DIM_BITS-1:0];
				CFG_HEIGHT:   cfg_q.height   <= cfg_data[DIM_BITS-1:0];
				CFG_ZOOM:     cfg_q.zoom     <= cfg_data[ZOOM_BITS-1:0];
				CFG_OFF_RE:   cfg_q.off_re   <= cfg_data;
				CFG_OFF_IM:   cfg_q.off_im   <= cfg_data;
				CFG_C_RE:     cfg_q.c_re     <= cfg_data;
				CFG_C_IM:     cfg_q.c_im     <= cfg_data;
				CFG_MAX_ITER: cfg_q.max_iter <= cfg_data[ITER_BITS-1:0];
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	jets_ctrl #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	jets_datapath #(.FRAC_BITS(FRAC_BITS), .COORD_BITS(COORD_BITS)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.sts            (sts),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.out_ready      (out_ready),
		.out_valid      (out_valid),
		.iteration_count(iteration_count),
		.inside_set     (inside_set),
		.final_real     (final_real),
		.final_imag     (final_imag)
	);

endmodule

[sv/jets_div.sv]
// Bit-serial restoring divider for the pixel to complex-plane mapping.
// Depends on jets_pkg; one quotient bit per step, quotient capped at QCAP.
module jets_div import jets_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int MAG_BITS  = HALF_BITS + 2
) (
	input  logic                clk,
	input  logic                start,
	input  logic                step,
	input  logic [MAG_BITS-1:0] mag,
	input  logic [DEN_BITS-1:0] den,
	output logic [QW-1:0]       quot
);

	localparam int DVD_W = MAG_BITS + 2 * FRAC_BITS;

	logic [DVD_W-1:0]    dvd_q;
	logic [DEN_BITS-1:0] rem_q;
	logic [QW-1:0]       quo_q;
	logic [DEN_BITS:0]   r_sh;
	logic [DEN_BITS:0]   r_sub;
	logic                ge;

	// Bring down the next dividend bit and trial-subtract
	assign r_sh  = {rem_q, dvd_q[DVD_W-1]};
	assign r_sub = r_sh - {1'b0, den};
	assign ge    = (r_sh >= {1'b0, den});

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {mag, {(2 * FRAC_BITS){1'b0}}};
			rem_q <= '0;
			quo_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= ge ? r_sub[DEN_BITS-1:0] : r_sh[DEN_BITS-1:0];
			// hold at the cap once reached
			quo_q <= (quo_q >= QCAP) ? QCAP : {quo_q[QW-2:0], ge};
		end
	end

	assign quot = (quo_q > QCAP) ? QCAP : quo_q;

endmodule

[sv/jets_datapath.sv]
// Datapath: start-point mapping, shared complex square-and-add unit, result register.
// Depends on jets_pkg and jets_div; driven by jets_ctrl through jets_cmd_t.
module jets_datapath import jets_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jets_cfg_t             cfg,
	input  jets_cmd_t             cmd,
	output jets_sts_t             sts,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  logic                  out_ready,
	output logic                  out_valid,
	output logic [ITER_BITS-1:0]  iteration_count,
	output logic                  inside_set,
	output logic signed [31:0]    final_real,
	output logic signed [31:0]    final_imag
);

	localparam int            SPAN     = (COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS;
	localparam int            DW       = SPAN + 1;
	localparam int            MAG_BITS = DW + 1;
	localparam bit            ESC_ON   = (2 * FRAC_BITS + 2) < 64;
	localparam logic [63:0]   THRESH   = ESC_ON ? (64'd4 << (2 * FRAC_BITS)) : '0;

	logic [COORD_BITS-1:0] px_q, py_q;
	logic [DEN_BITS-1:0]   den_x_q, den_y_q;
	logic                  neg_x_q, neg_y_q;
	logic signed [31:0]    zr_q, zi_q;
	logic signed [63:0]    rr_q, ii_q, ri_q;
	logic [ITER_BITS-1:0]  k_q;
	logic                  out_valid_q;

	logic [DIM_BITS-1:0]   w1, h1;
	logic [ZOOM_BITS-1:0]  zm1;
	logic signed [DW-1:0]  dx, dy, ax, ay;
	logic [MAG_BITS-1:0]   mag_x, mag_y;
	logic [QW-1:0]         qx, qy;
	logic signed [QW:0]    sx, sy;
	logic signed [63:0]    diff;
	logic [63:0]           mag;
	logic signed [31:0]    nr, ni, mr, mi;

	// Zero width, height or zoom act as one
	assign w1  = (cfg.width  == '0) ? DIM_BITS'(1)  : cfg.width;
	assign h1  = (cfg.height == '0) ? DIM_BITS'(1)  : cfg.height;
	assign zm1 = (cfg.zoom   == '0) ? ZOOM_BITS'(1) : cfg.zoom;

	// Centered coordinates in sign-magnitude form
	assign dx    = $signed(DW'(px_q)) - $signed(DW'(w1[DIM_BITS-1:1]));
	assign dy    = $signed(DW'(py_q)) - $signed(DW'(h1[DIM_BITS-1:1]));
	assign ax    = dx[DW-1] ? -dx : dx;
	assign ay    = dy[DW-1] ? -dy : dy;
	assign mag_x = MAG_BITS'(ax[DW-2:0]) * MAG_BITS'(2'd3);
	assign mag_y = {1'b0, ay[DW-2:0], 1'b0};

	jets_div #(.FRAC_BITS(FRAC_BITS), .MAG_BITS(MAG_BITS)) u_div_x (
		.clk  (clk),
		.start(cmd.setup),
		.step (cmd.div_step),
		.mag  (mag_x),
		.den  (den_x_q),
		.quot (qx)
	);

	jets_div #(.FRAC_BITS(FRAC_BITS), .MAG_BITS(MAG_BITS)) u_div_y (
		.clk  (clk),
		.start(cmd.setup),
		.step (cmd.div_step),
		.mag  (mag_y),
		.den  (den_y_q),
		.quot (qy)
	);

	// Start point: signed quotient plus pan offset
	assign sx = neg_x_q ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
	assign sy = neg_y_q ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
	assign mr = sat32(SAT_W'(sx) + SAT_W'(cfg.off_re));
	assign mi = sat32(SAT_W'(sy) + SAT_W'(cfg.off_im));

	// Next z from the registered products, floor shift then add c
	assign diff = rr_q - ii_q;
	assign nr   = sat32(SAT_W'(diff >>> FRAC_BITS) + SAT_W'(cfg.c_re));
	assign ni   = sat32(SAT_W'(ri_q >>> (FRAC_BITS - 1)) + SAT_W'(cfg.c_im));

	// Escape test on the current z; no test before the first step
	assign mag          = rr_q + ii_q;
	assign sts.esc      = ESC_ON && (k_q != '0) && (mag > THRESH);
	assign sts.at_limit = (k_q == cfg.max_iter);
	assign sts.out_busy = out_valid_q && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		if (cmd.setup) begin
			den_x_q <= DEN_BITS'(zm1) * DEN_BITS'(w1);
			den_y_q <= DEN_BITS'(zm1) * DEN_BITS'(h1);
			neg_x_q <= dx[DW-1];
			neg_y_q <= dy[DW-1];
		end
		if (cmd.map) begin
			zr_q <= mr;
			zi_q <= mi;
			k_q  <= '0;
		end else if (cmd.step) begin
			zr_q <= nr;
			zi_q <= ni;
			k_q  <= ITER_BITS'(k_q + ITER_BITS'(1));
		end
		if (cmd.mult) begin
			rr_q <= 64'(zr_q) * 64'(zr_q);
			ii_q <= 64'(zi_q) * 64'(zi_q);
			ri_q <= 64'(zr_q) * 64'(zi_q);
		end
		// Result register; count equals the last step run in both outcomes
		if (cmd.out_load) begin
			iteration_count <= k_q;
			inside_set      <= !sts.esc;
			final_real      <= zr_q;
			final_imag      <= zi_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

[sv/jets_ctrl.sv]
// Controller for the Julia pixel unit: sequences setup, division and iteration.
// Depends on jets_pkg; talks to jets_datapath through jets_cmd_t and jets_sts_t.
module jets_ctrl import jets_pkg::*; #(
	parameter int FRAC_BITS  = FRAC_BITS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  jets_sts_t sts,
	output jets_cmd_t cmd
);

	localparam int SPAN      = (COORD_BITS > HALF_BITS) ? COORD_BITS : HALF_BITS;
	localparam int DIV_STEPS = SPAN + 2 + 2 * FRAC_BITS;
	localparam int CW        = $clog2(DIV_STEPS);

	jets_state_t   state_q, state_d;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			// count division steps
			if (state_q == ST_SETUP)
				cnt_q <= '0;
			else if (state_q == ST_DIV)
				cnt_q <= CW'(cnt_q + CW'(1));
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CW'(DIV_STEPS - 1))
					state_d = ST_MAP;
			end
			ST_MAP: begin
				cmd.map = 1'b1;
				state_d = ST_MULT;
			end
			ST_MULT: begin
				cmd.mult = 1'b1;
				state_d  = ST_STEP;
			end
			ST_STEP: begin
				// stop on escape or at the limit, else advance one step
				if (sts.esc || sts.at_limit) begin
					state_d = ST_FINISH;
				end else begin
					cmd.step = 1'b1;
					state_d  = ST_MULT;
				end
			end
			ST_FINISH: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[sv/jets_checker.sv]
// Port-level checks for julia_escape_time_pixel, attached by the bind below.
// Depends on jets_pkg for the count width only.
module jets_checker import jets_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [ITER_BITS-1:0] iteration_count,
	input logic                 inside_set,
	input logic signed [31:0]   final_real,
	input logic signed [31:0]   final_imag
);

	// Stay busy through setup and the first division step after a pixel beat
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready ##1 !in_ready)
		else $error("input taken again right after a pixel beat");

	// An escape is never reported before the first step
	a_escape_count: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !inside_set) |-> (iteration_count != '0))
		else $error("escape reported with a zero count");

	// Hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(iteration_count)
			&& $stable(inside_set) && $stable(final_real) && $stable(final_imag))
		else $error("stalled result beat changed");

endmodule

bind julia_escape_time_pixel jets_checker u_jets_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.iteration_count(iteration_count),
	.inside_set     (inside_set),
	.final_real     (final_real),
	.final_imag     (final_imag)
);
